FILE: hw/rtl/mbrtu_pkg.sv
package mbrtu_pkg;

    localparam int TABLE_WORDS_DEF    = 256;
    localparam int MAX_READ_COUNT_DEF = 125;
    localparam int REQUEST_BYTES      = 8;

    localparam logic [7:0]  FN_READ_INPUT = 8'h04;
    localparam logic [7:0]  EX_FUNCTION   = 8'h01;
    localparam logic [7:0]  EX_ADDRESS    = 8'h02;
    localparam logic [7:0]  EX_VALUE      = 8'h03;
    localparam logic [7:0]  EX_FAILURE    = 8'h04;
    localparam logic [7:0]  EXC_FLAG      = 8'h80;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_TABLE_WRITE = 2'd1,
        OP_PUBLISH = 2'd2,
        OP_LINK_DROP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_UNIT_ID = 2'd0,
        CFG_FIRST_ADDR = 2'd1,
        CFG_LAST_ADDR = 2'd2
    } cfg_idx_t;

    function automatic logic [15:0] crc_bit_step(input logic [15:0] c);
        crc_bit_step = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction

endpackage

FILE: hw/rtl/modbus_rtu_input_register_server.sv
// Modbus RTU server for Read Input Registers (function 0x04).
// Input channel (in_valid/in_ready) carries one beat per event: a received
// serial byte, a table word write, a publish command or a link drop.
// Eight serial bytes form one request. A request with a bad CRC or a foreign
// unit id is dropped; otherwise a reply frame leaves on the output channel
// (out_valid/out_ready) as groups of up to four bytes, frame_end on the last.
// Configuration registers are written through cfg_we/cfg_index/cfg_data.
// Sequence: each received byte among the first six is accepted and then
// passes through the bit-serial CRC unit; the last two are only stored.
// Checking a complete request takes state S_CHK, followed by S_ADDR when it
// reaches the address check. Every reply byte that enters the CRC passes
// through the same unit; table words are fetched in S_FETCH, and the CRC
// bytes bypass the unit. Request bytes and reply bytes share the single
// bit-serial CRC unit. in_ready is low while a byte is being checked or a
// reply is being built.
// A stalled receiver holds the output register; the sequencer waits at the
// end of each group until that register is free.
// Reset clears the request fill count and the published flag and loads the
// configuration defaults (unit id 1, window 0 to 255). The table content is
// undefined until written.
module modbus_rtu_input_register_server
    import mbrtu_pkg::*;
#(
    parameter int TABLE_WORDS    = TABLE_WORDS_DEF,
    parameter int MAX_READ_COUNT = MAX_READ_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  table_index,
    input  logic [15:0] table_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte_a,
    output logic [7:0]  tx_byte_b,
    output logic [7:0]  tx_byte_c,
    output logic [7:0]  tx_byte_d,
    output logic [2:0]  bytes_valid,
    output logic        frame_end
);

    localparam int AW = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
    localparam logic [17:0] TW = 18'(TABLE_WORDS);
    localparam logic [15:0] MAXC = 16'(MAX_READ_COUNT);

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_CHK, S_ADDR, S_BYTE, S_FETCH, S_EMIT
    } state_t;

    state_t      state_reg, ret_reg;
    logic [7:0]  unit_id_reg;
    logic [15:0] first_addr_reg, last_addr_reg;
    logic [7:0]  req_buf_reg [REQUEST_BYTES];
    logic [2:0]  fill_reg;
    logic        published_reg;
    logic [15:0] crc_reg;
    logic [2:0]  bit_cnt_reg;
    logic        is_exc_reg;
    logic [7:0]  code_reg;
    logic [7:0]  len_reg, bidx_reg;
    logic [AW-1:0] addr_reg;
    logic        have_word_reg;
    logic [15:0] rd_data_reg;
    logic [7:0]  gb_reg [4];
    logic [2:0]  gcnt_reg;
    logic        last_grp_reg;
    logic        ov_reg;
    logic [7:0]  ob_reg [4];
    logic [2:0]  obv_reg;
    logic        ofe_reg;

    logic [15:0] mem [TABLE_WORDS];

    logic        accept;
    logic        fetch_en;
    logic        emit_load;
    logic [15:0] start_w, count_w;
    logic [16:0] last_w;
    logic [15:0] offset_w;
    logic [17:0] span_w;
    logic [7:0]  cur_byte;
    logic        crc_pos;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign fetch_en  = (state_reg == S_FETCH);
    assign emit_load = (state_reg == S_EMIT) && (!ov_reg || out_ready);

    assign start_w  = {req_buf_reg[2], req_buf_reg[3]};
    assign count_w  = {req_buf_reg[4], req_buf_reg[5]};
    assign last_w   = {1'b0, start_w} + {1'b0, count_w} - 17'd1;
    assign offset_w = start_w - first_addr_reg;
    assign span_w   = {2'b00, offset_w} + {2'b00, count_w};
    assign crc_pos  = (bidx_reg >= len_reg - 8'd2);

    always_comb
    begin
        if (bidx_reg == 8'd0)
            cur_byte = unit_id_reg;
        else if (bidx_reg == 8'd1)
            cur_byte = is_exc_reg ? (req_buf_reg[1] | EXC_FLAG) : req_buf_reg[1];
        else if (bidx_reg == 8'd2)
            cur_byte = is_exc_reg ? code_reg : {count_w[6:0], 1'b0};
        else if (bidx_reg == len_reg - 8'd2)
            cur_byte = crc_reg[7:0];
        else if (bidx_reg == len_reg - 8'd1)
            cur_byte = crc_reg[15:8];
        else
            cur_byte = bidx_reg[0] ? rd_data_reg[15:8] : rd_data_reg[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_TABLE_WRITE && int'(table_index) < TABLE_WORDS)
            mem[AW'(table_index)] <= table_value;
        if (fetch_en)
            rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            unit_id_reg    <= 8'd1;
            first_addr_reg <= 16'd0;
            last_addr_reg  <= 16'd255;
            fill_reg       <= '0;
            published_reg  <= 1'b0;
            bit_cnt_reg    <= '0;
            ov_reg         <= 1'b0;
            gcnt_reg       <= '0;
            have_word_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_UNIT_ID:    unit_id_reg    <= cfg_data[7:0];
                    CFG_FIRST_ADDR: first_addr_reg <= cfg_data;
                    CFG_LAST_ADDR:  last_addr_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (emit_load)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (opcode)
                            OP_TABLE_WRITE: ;
                            OP_PUBLISH:     published_reg <= 1'b1;
                            OP_LINK_DROP:   fill_reg <= '0;
                            OP_RX_BYTE:
                            begin
                                req_buf_reg[fill_reg] <= rx_byte;
                                if (fill_reg == 3'd7)
                                begin
                                    fill_reg  <= '0;
                                    state_reg <= S_CHK;
                                end
                                else
                                begin
                                    fill_reg <= fill_reg + 3'd1;
                                    if (fill_reg < 3'd6)
                                    begin
                                        // fold the byte in, then shift it through
                                        crc_reg     <= ((fill_reg == 3'd0) ? CRC_INIT : crc_reg)
                                                       ^ {8'd0, rx_byte};
                                        bit_cnt_reg <= '0;
                                        ret_reg     <= S_IDLE;
                                        state_reg   <= S_SHIFT;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SHIFT:
                begin
                    crc_reg     <= crc_bit_step(crc_reg);
                    bit_cnt_reg <= bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == 3'd7)
                        state_reg <= ret_reg;
                end
                S_CHK:
                begin
                    is_exc_reg <= 1'b1;
                    len_reg    <= 8'd5;
                    if (crc_reg != {req_buf_reg[7], req_buf_reg[6]}
                        || req_buf_reg[0] != unit_id_reg)
                        state_reg <= S_IDLE;
                    else if (req_buf_reg[1] != FN_READ_INPUT)
                    begin
                        code_reg  <= EX_FUNCTION;
                        state_reg <= S_BYTE;
                    end
                    else if (count_w == 16'd0 || count_w > MAXC)
                    begin
                        code_reg  <= EX_VALUE;
                        state_reg <= S_BYTE;
                    end
                    else
                        state_reg <= S_ADDR;
                    crc_reg      <= CRC_INIT;
                    bidx_reg     <= '0;
                    gcnt_reg     <= '0;
                    last_grp_reg <= 1'b0;
                    for (int k = 0; k < 4; k++)
                        gb_reg[k] <= '0;
                end
                S_ADDR:
                begin
                    state_reg <= S_BYTE;
                    if (start_w < first_addr_reg || last_w > {1'b0, last_addr_reg}
                        || span_w > TW)
                        code_reg <= EX_ADDRESS;
                    else if (!published_reg)
                        code_reg <= EX_FAILURE;
                    else
                    begin
                        is_exc_reg    <= 1'b0;
                        len_reg       <= 8'({count_w[6:0], 1'b0}) + 8'd5;
                        addr_reg      <= AW'(offset_w);
                        have_word_reg <= 1'b0;
                    end
                end
                S_FETCH:
                begin
                    addr_reg      <= addr_reg + AW'(1);
                    have_word_reg <= 1'b1;
                    state_reg     <= S_BYTE;
                end
                S_BYTE:
                begin
                    if (!is_exc_reg && bidx_reg >= 8'd3 && !crc_pos && bidx_reg[0]
                        && !have_word_reg)
                        state_reg <= S_FETCH;
                    else
                    begin
                        if (!is_exc_reg && bidx_reg >= 8'd3 && !crc_pos && !bidx_reg[0])
                            have_word_reg <= 1'b0;
                        gb_reg[gcnt_reg[1:0]] <= cur_byte;
                        gcnt_reg     <= gcnt_reg + 3'd1;
                        bidx_reg     <= bidx_reg + 8'd1;
                        last_grp_reg <= (bidx_reg == len_reg - 8'd1);
                        if (crc_pos)
                        begin
                            state_reg <= (gcnt_reg == 3'd3 || bidx_reg == len_reg - 8'd1)
                                         ? S_EMIT : S_BYTE;
                        end
                        else
                        begin
                            crc_reg     <= crc_reg ^ {8'd0, cur_byte};
                            bit_cnt_reg <= '0;
                            ret_reg     <= (gcnt_reg == 3'd3) ? S_EMIT : S_BYTE;
                            state_reg   <= S_SHIFT;
                        end
                    end
                end
                S_EMIT:
                begin
                    // hold the group until the output register is free
                    if (emit_load)
                    begin
                        obv_reg <= gcnt_reg;
                        ofe_reg <= last_grp_reg;
                        for (int k = 0; k < 4; k++)
                        begin
                            ob_reg[k] <= gb_reg[k];
                            gb_reg[k] <= '0;
                        end
                        gcnt_reg  <= '0;
                        state_reg <= last_grp_reg ? S_IDLE : S_BYTE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = ov_reg;
    assign tx_byte_a   = ob_reg[0];
    assign tx_byte_b   = ob_reg[1];
    assign tx_byte_c   = ob_reg[2];
    assign tx_byte_d   = ob_reg[3];
    assign bytes_valid = obv_reg;
    assign frame_end   = ofe_reg;

`ifndef SYNTHESIS
    a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bytes_valid != 3'd0 && bytes_valid <= 3'd4))
        else $error("group byte count out of range");
    a_full_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_end) |-> bytes_valid == 3'd4)
        else $error("short group before frame end");
    a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_RX_BYTE && fill_reg == 3'd7) |=> state_reg == S_CHK)
        else $error("complete request not checked");
    a_group_fill: assert property (@(posedge clk) disable iff (!rst_n)
        gcnt_reg <= 3'd4)
        else $error("group buffer overfilled");
`endif

endmodule
